// ===== sv/i2cbt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cbt_pkg
// Types and constants for the I2C block transfer master.
// ----------------------------------------------------------------------------
package i2cbt_pkg;

  localparam int MAX_BYTES      = 64;
  localparam int SELECT_RETRIES = 10;
  localparam int CNT_W          = 7;
  localparam int BUF_AW         = $clog2(MAX_BYTES);

  localparam logic [7:0] DEV_ADDR_RST = 8'hD0;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_START = 7'b0000010,
    PH_SEND  = 7'b0000100,
    PH_SACK  = 7'b0001000,
    PH_RECV  = 7'b0010000,
    PH_RACK  = 7'b0100000,
    PH_STOP  = 7'b1000000
  } phase_t;

  typedef enum logic [4:0] {
    STG_DEV  = 5'b00001,
    STG_REG  = 5'b00010,
    STG_RDEV = 5'b00100,
    STG_DATA = 5'b01000,
    STG_RD   = 5'b10000
  } stage_t;

endpackage
`default_nettype wire

// ===== sv/i2c_block_transfer_master_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_block_transfer_master_unit
// Open-drain I2C master, one bus delay slot per item: block register reads
// and buffered block writes with device select retry.
// ----------------------------------------------------------------------------
// The result of an accepted item is registered in the output register.
// 1 item per cycle unless stalled; the slot sequencer updates once per item.
// The write buffer is a 64-entry memory; its read port prefetches the next
// byte to send into a register, so no slot waits on it.
// Reset (rst, synchronous): sequencer idle, counters and pointers zero, lines
// released, device_address 0xD0. Write buffer contents are not cleared.
module i2c_block_transfer_master_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] opcode,
  input  wire logic       sda_in,
  input  wire logic [7:0] reg_address,
  input  wire logic [6:0] byte_count,
  input  wire logic [7:0] load_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            scl_low,
  output logic            sda_low,
  output logic            read_valid,
  output logic [7:0]      read_byte,
  output logic            done_res,
  output logic            success,
  output logic            busy_res,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  localparam logic [i2cbt_pkg::CNT_W-1:0] MAX_CNT =
    i2cbt_pkg::CNT_W'(i2cbt_pkg::MAX_BYTES);

  logic [7:0] device_address;

  i2cbt_pkg::phase_t phase, phase_next;
  i2cbt_pkg::stage_t stage, stage_next;
  logic [1:0] slot_in_bit, slot_in_bit_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [i2cbt_pkg::CNT_W-1:0] bytes_left, bytes_left_next;
  logic [3:0] retries_left, retries_left_next;
  logic is_read, is_read_next;
  logic [7:0] start_address, start_address_next;
  logic [i2cbt_pkg::CNT_W-1:0] fill_pointer, fill_pointer_next;
  logic [i2cbt_pkg::CNT_W-1:0] send_pointer, send_pointer_next;
  logic scl_drv, scl_drv_next;
  logic sda_drv, sda_drv_next;
  logic ack_seen, ack_seen_next;

  logic       rv_next;
  logic [7:0] rb_next;
  logic       done_next;
  logic       succ_next;
  logic       busy_next;
  logic       load_hit;
  logic [i2cbt_pkg::CNT_W-1:0] cnt;

  logic [7:0] wbuf [i2cbt_pkg::MAX_BYTES];
  logic [7:0] pre_byte;
  logic       accept;
  logic [i2cbt_pkg::CNT_W-1:0] send_ptr_rd;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= i2cbt_pkg::DEV_ADDR_RST;
    end else if (cfg_valid && cfg_ready) begin
      device_address <= cfg_data;
    end
  end

  always_comb begin
    phase_next         = phase;
    stage_next         = stage;
    slot_in_bit_next   = slot_in_bit;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    bytes_left_next    = bytes_left;
    retries_left_next  = retries_left;
    is_read_next       = is_read;
    start_address_next = start_address;
    fill_pointer_next  = fill_pointer;
    send_pointer_next  = send_pointer;
    scl_drv_next       = scl_drv;
    sda_drv_next       = sda_drv;
    ack_seen_next      = ack_seen;
    rv_next            = 1'b0;
    rb_next            = 8'd0;
    done_next          = 1'b0;
    succ_next          = 1'b0;
    busy_next          = 1'b0;
    load_hit           = 1'b0;
    cnt = (byte_count > MAX_CNT) ? MAX_CNT : byte_count;

    // commands are taken only while idle
    if (phase == i2cbt_pkg::PH_IDLE) begin
      if (opcode == i2cbt_pkg::OP_LOAD) begin
        if (fill_pointer < MAX_CNT) begin
          load_hit          = 1'b1;
          fill_pointer_next = fill_pointer + 1'b1;
        end
      end else if (opcode inside {i2cbt_pkg::OP_READ, i2cbt_pkg::OP_WRITE}) begin
        is_read_next = (opcode == i2cbt_pkg::OP_READ);
        if (opcode == i2cbt_pkg::OP_WRITE) begin
          fill_pointer_next = '0;
        end
        if (cnt == '0) begin
          done_next = 1'b1;
        end else begin
          bytes_left_next    = cnt;
          start_address_next = reg_address;
          retries_left_next  = 4'(i2cbt_pkg::SELECT_RETRIES);
          send_pointer_next  = '0;
          stage_next         = i2cbt_pkg::STG_DEV;
          ack_seen_next      = 1'b0;
          shift_byte_next    = 8'd0;
          phase_next         = i2cbt_pkg::PH_START;
          slot_in_bit_next   = 2'd0;
          bit_index_next     = 4'd0;
        end
      end
    end

    if (phase_next != i2cbt_pkg::PH_IDLE) begin
      busy_next = 1'b1;
      case (phase_next)
        i2cbt_pkg::PH_START: begin
          case (slot_in_bit_next)
            2'd0:    sda_drv_next = 1'b0;
            2'd1:    scl_drv_next = 1'b0;
            2'd2:    sda_drv_next = 1'b1;
            default: scl_drv_next = 1'b1;
          endcase
          if (slot_in_bit_next != 2'd3) begin
            slot_in_bit_next = slot_in_bit_next + 2'd1;
          end else begin
            if (stage_next == i2cbt_pkg::STG_RDEV) begin
              shift_byte_next = device_address | 8'd1;
            end else begin
              stage_next      = i2cbt_pkg::STG_DEV;
              shift_byte_next = device_address;
            end
            phase_next       = i2cbt_pkg::PH_SEND;
            slot_in_bit_next = 2'd0;
            bit_index_next   = 4'd0;
          end
        end
        i2cbt_pkg::PH_SEND: begin
          if (slot_in_bit_next == 2'd0) begin
            sda_drv_next     = ~shift_byte_next[7];
            slot_in_bit_next = 2'd1;
          end else if (slot_in_bit_next == 2'd1) begin
            scl_drv_next     = 1'b0;
            slot_in_bit_next = 2'd2;
          end else begin
            scl_drv_next     = 1'b1;
            shift_byte_next  = {shift_byte_next[6:0], 1'b0};
            bit_index_next   = bit_index_next + 4'd1;
            slot_in_bit_next = 2'd0;
            if (bit_index_next >= 4'd8) begin
              phase_next     = i2cbt_pkg::PH_SACK;
              bit_index_next = 4'd0;
            end
          end
        end
        i2cbt_pkg::PH_SACK: begin
          if (slot_in_bit_next == 2'd0) begin
            sda_drv_next     = 1'b0;
            slot_in_bit_next = 2'd1;
          end else if (slot_in_bit_next == 2'd1) begin
            scl_drv_next     = 1'b0;
            ack_seen_next    = ~sda_in;
            slot_in_bit_next = 2'd2;
          end else begin
            scl_drv_next     = 1'b1;
            slot_in_bit_next = 2'd0;
            bit_index_next   = 4'd0;
            if (stage_next == i2cbt_pkg::STG_DEV) begin
              if (ack_seen_next) begin
                stage_next      = i2cbt_pkg::STG_REG;
                shift_byte_next = start_address_next;
                phase_next      = i2cbt_pkg::PH_SEND;
              end else begin
                if (retries_left_next != 4'd0) begin
                  retries_left_next = retries_left_next - 4'd1;
                end
                phase_next = (retries_left_next == 4'd0) ? i2cbt_pkg::PH_STOP
                                                         : i2cbt_pkg::PH_START;
              end
            end else if (!ack_seen_next) begin
              phase_next = i2cbt_pkg::PH_STOP;
            end else if (stage_next == i2cbt_pkg::STG_REG) begin
              if (is_read_next) begin
                stage_next = i2cbt_pkg::STG_RDEV;
                phase_next = i2cbt_pkg::PH_START;
              end else begin
                // pre_byte holds the entry at send_pointer; step past it
                stage_next        = i2cbt_pkg::STG_DATA;
                shift_byte_next   = pre_byte;
                send_pointer_next = send_pointer_next + 1'b1;
                phase_next        = i2cbt_pkg::PH_SEND;
              end
            end else if (stage_next == i2cbt_pkg::STG_RDEV) begin
              stage_next      = i2cbt_pkg::STG_RD;
              shift_byte_next = 8'd0;
              phase_next      = i2cbt_pkg::PH_RECV;
            end else begin
              if (bytes_left_next != '0) begin
                bytes_left_next = bytes_left_next - 1'b1;
              end
              if (bytes_left_next == '0) begin
                phase_next = i2cbt_pkg::PH_STOP;
              end else begin
                shift_byte_next   = pre_byte;
                send_pointer_next = send_pointer_next + 1'b1;
                phase_next        = i2cbt_pkg::PH_SEND;
              end
            end
          end
        end
        i2cbt_pkg::PH_RECV: begin
          if (slot_in_bit_next == 2'd0) begin
            scl_drv_next    = 1'b0;
            shift_byte_next = {shift_byte_next[6:0], sda_in};
            if (bit_index_next >= 4'd7) begin
              rv_next = 1'b1;
              rb_next = shift_byte_next;
            end
            slot_in_bit_next = 2'd1;
          end else begin
            scl_drv_next     = 1'b1;
            bit_index_next   = bit_index_next + 4'd1;
            slot_in_bit_next = 2'd0;
            if (bit_index_next >= 4'd8) begin
              if (bytes_left_next != '0) begin
                bytes_left_next = bytes_left_next - 1'b1;
              end
              phase_next     = i2cbt_pkg::PH_RACK;
              bit_index_next = 4'd0;
            end
          end
        end
        i2cbt_pkg::PH_RACK: begin
          if (slot_in_bit_next == 2'd0) begin
            sda_drv_next     = (bytes_left_next != '0);
            slot_in_bit_next = 2'd1;
          end else if (slot_in_bit_next == 2'd1) begin
            scl_drv_next     = 1'b0;
            slot_in_bit_next = 2'd2;
          end else begin
            scl_drv_next     = 1'b1;
            sda_drv_next     = 1'b0;
            slot_in_bit_next = 2'd0;
            bit_index_next   = 4'd0;
            if (bytes_left_next != '0) begin
              shift_byte_next = 8'd0;
              phase_next      = i2cbt_pkg::PH_RECV;
            end else begin
              phase_next = i2cbt_pkg::PH_STOP;
            end
          end
        end
        default: begin
          if (slot_in_bit_next == 2'd0) begin
            sda_drv_next     = 1'b1;
            slot_in_bit_next = 2'd1;
          end else if (slot_in_bit_next == 2'd1) begin
            scl_drv_next     = 1'b0;
            slot_in_bit_next = 2'd2;
          end else begin
            sda_drv_next     = 1'b0;
            done_next        = 1'b1;
            succ_next        = (bytes_left_next == '0);
            phase_next       = i2cbt_pkg::PH_IDLE;
            slot_in_bit_next = 2'd0;
            bit_index_next   = 4'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= i2cbt_pkg::PH_IDLE;
      stage         <= i2cbt_pkg::STG_DEV;
      slot_in_bit   <= 2'd0;
      bit_index     <= 4'd0;
      shift_byte    <= 8'd0;
      bytes_left    <= '0;
      retries_left  <= 4'd0;
      is_read       <= 1'b0;
      start_address <= 8'd0;
      fill_pointer  <= '0;
      send_pointer  <= '0;
      scl_drv       <= 1'b0;
      sda_drv       <= 1'b0;
      ack_seen      <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      stage         <= stage_next;
      slot_in_bit   <= slot_in_bit_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      bytes_left    <= bytes_left_next;
      retries_left  <= retries_left_next;
      is_read       <= is_read_next;
      start_address <= start_address_next;
      fill_pointer  <= fill_pointer_next;
      send_pointer  <= send_pointer_next;
      scl_drv       <= scl_drv_next;
      sda_drv       <= sda_drv_next;
      ack_seen      <= ack_seen_next;
    end
  end

  // write buffer; read port is addressed by the next send pointer on accept
  assign send_ptr_rd = accept ? send_pointer_next : send_pointer;

  always_ff @(posedge clk) begin
    if (accept && load_hit) begin
      wbuf[fill_pointer[i2cbt_pkg::BUF_AW-1:0]] <= load_byte;
    end
    pre_byte <= wbuf[send_ptr_rd[i2cbt_pkg::BUF_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scl_low    <= scl_drv_next;
      sda_low    <= sda_drv_next;
      read_valid <= rv_next;
      read_byte  <= rb_next;
      done_res   <= done_next;
      success    <= succ_next;
      busy_res   <= busy_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_success_with_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && success) |-> done_res)
    else $error("success without done");

  a_read_while_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_valid) |-> (busy_res && !done_res))
    else $error("read byte outside a transfer");

  a_idle_tick_quiet: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == i2cbt_pkg::PH_IDLE && opcode == i2cbt_pkg::OP_TICK)
      |=> (!busy_res && !done_res && !scl_low && !sda_low))
    else $error("idle tick produced bus activity");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (bytes_left <= MAX_CNT) && (fill_pointer <= MAX_CNT))
    else $error("count beyond buffer depth");

  a_retry_bound: assert property (@(posedge clk) disable iff (rst)
    retries_left <= 4'(i2cbt_pkg::SELECT_RETRIES))
    else $error("retry count out of range");
`endif

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - I2C block transfer master unit
// Drives bus delay slots, block reads and buffered block writes against a
// simulated device that ACKs, NACKs and returns random data. A slot-accurate
// model of the master predicts every result item, and a scoreboard checks the
// items in order. Device address changes between phases while the unit idles.
// ----------------------------------------------------------------------------
package i2cbt_tb_pkg;

  typedef struct packed {
    logic [1:0] op;
    logic       sda;
    logic [7:0] reg_addr;
    logic [6:0] cnt;
    logic [7:0] data;
  } slot_in_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       done;
    logic       ok;
    logic       busy;
  } slot_out_t;

  class slot_scoreboard;
    // master model state
    i2cbt_pkg::phase_t ph;
    i2cbt_pkg::stage_t stg;
    bit [1:0]  slot;
    bit [3:0]  bit_idx;
    bit [7:0]  shift;
    bit [6:0]  left;
    bit [3:0]  retries;
    bit        is_rd;
    bit [7:0]  start_addr;
    bit [7:0]  wbuf [i2cbt_pkg::MAX_BYTES];
    bit [6:0]  fill;
    bit [6:0]  sendp;
    bit        scl_l;
    bit        sda_l;
    bit        ack;
    bit [7:0]  dev_addr;
    int        written;
    slot_out_t res;
    slot_out_t pending_slots [$];
    int        errors;
    int        checked;

    function new();
      ph = i2cbt_pkg::PH_IDLE;
      stg = i2cbt_pkg::STG_DEV;
      slot = '0;
      bit_idx = '0;
      shift = '0;
      left = '0;
      retries = '0;
      is_rd = 1'b0;
      start_addr = '0;
      foreach (wbuf[i]) wbuf[i] = '0;
      fill = '0;
      sendp = '0;
      scl_l = 1'b0;
      sda_l = 1'b0;
      ack = 1'b0;
      dev_addr = i2cbt_pkg::DEV_ADDR_RST;
      written = 0;
      errors = 0;
      checked = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    function void send_byte(bit [7:0] b);
      ph = i2cbt_pkg::PH_SEND;
      slot = '0;
      bit_idx = '0;
      shift = b;
    endfunction

    function void enter(i2cbt_pkg::phase_t p);
      ph = p;
      slot = '0;
      bit_idx = '0;
    endfunction

    function bit [7:0] buffered();
      if (sendp < i2cbt_pkg::MAX_BYTES) return wbuf[sendp[5:0]];
      return 8'h00;
    endfunction

    function void after_ack();
      if (stg == i2cbt_pkg::STG_DEV) begin
        if (ack) begin
          stg = i2cbt_pkg::STG_REG;
          send_byte(start_addr);
        end else begin
          if (retries != 0) retries--;
          if (retries == 0) enter(i2cbt_pkg::PH_STOP);
          else enter(i2cbt_pkg::PH_START);
        end
      end else if (!ack) begin
        enter(i2cbt_pkg::PH_STOP);
      end else if (stg == i2cbt_pkg::STG_REG) begin
        if (is_rd) begin
          stg = i2cbt_pkg::STG_RDEV;
          enter(i2cbt_pkg::PH_START);
        end else begin
          stg = i2cbt_pkg::STG_DATA;
          send_byte(buffered());
        end
      end else if (stg == i2cbt_pkg::STG_RDEV) begin
        stg = i2cbt_pkg::STG_RD;
        shift = '0;
        enter(i2cbt_pkg::PH_RECV);
      end else begin
        sendp++;
        if (left != 0) left--;
        if (left == 0) enter(i2cbt_pkg::PH_STOP);
        else send_byte(buffered());
      end
    endfunction

    function void advance_bus(bit sda_s);
      res.busy = 1'b1;
      case (ph)
        i2cbt_pkg::PH_START: begin
          case (slot)
            2'd0: sda_l = 1'b0;
            2'd1: scl_l = 1'b0;
            2'd2: sda_l = 1'b1;
            default: scl_l = 1'b1;
          endcase
          if (slot != 2'd3) slot++;
          else if (stg == i2cbt_pkg::STG_RDEV) send_byte(dev_addr | 8'h01);
          else begin
            stg = i2cbt_pkg::STG_DEV;
            send_byte(dev_addr);
          end
        end
        i2cbt_pkg::PH_SEND: begin
          if (slot == 2'd0) begin
            sda_l = !shift[7];
            slot = 2'd1;
          end else if (slot == 2'd1) begin
            scl_l = 1'b0;
            slot = 2'd2;
          end else begin
            scl_l = 1'b1;
            shift = {shift[6:0], 1'b0};
            bit_idx++;
            slot = 2'd0;
            if (bit_idx >= 8) enter(i2cbt_pkg::PH_SACK);
          end
        end
        i2cbt_pkg::PH_SACK: begin
          if (slot == 2'd0) begin
            sda_l = 1'b0;
            slot = 2'd1;
          end else if (slot == 2'd1) begin
            scl_l = 1'b0;
            ack = !sda_s;
            slot = 2'd2;
          end else begin
            scl_l = 1'b1;
            after_ack();
          end
        end
        i2cbt_pkg::PH_RECV: begin
          if (slot == 2'd0) begin
            scl_l = 1'b0;
            shift = {shift[6:0], sda_s};
            if (bit_idx >= 7) begin
              res.rd_valid = 1'b1;
              res.rd_byte = shift;
            end
            slot = 2'd1;
          end else begin
            scl_l = 1'b1;
            bit_idx++;
            slot = 2'd0;
            if (bit_idx >= 8) begin
              if (left != 0) left--;
              enter(i2cbt_pkg::PH_RACK);
            end
          end
        end
        i2cbt_pkg::PH_RACK: begin
          if (slot == 2'd0) begin
            sda_l = (left != 0);
            slot = 2'd1;
          end else if (slot == 2'd1) begin
            scl_l = 1'b0;
            slot = 2'd2;
          end else begin
            scl_l = 1'b1;
            sda_l = 1'b0;
            if (left != 0) begin
              shift = '0;
              enter(i2cbt_pkg::PH_RECV);
            end else begin
              enter(i2cbt_pkg::PH_STOP);
            end
          end
        end
        default: begin
          if (slot == 2'd0) begin
            sda_l = 1'b1;
            slot = 2'd1;
          end else if (slot == 2'd1) begin
            scl_l = 1'b0;
            slot = 2'd2;
          end else begin
            sda_l = 1'b0;
            res.done = 1'b1;
            res.ok = (left == 0);
            enter(i2cbt_pkg::PH_IDLE);
          end
        end
      endcase
    endfunction

    // Returns 0 for an item that the idle unit ignores.
    function bit take_item(slot_in_t it);
      int n;
      bit counted;
      res = '0;
      counted = 1'b1;
      if (ph == i2cbt_pkg::PH_IDLE) begin
        if (it.op == i2cbt_pkg::OP_TICK) begin
          counted = 1'b0;
        end else if (it.op == i2cbt_pkg::OP_LOAD) begin
          if (fill < i2cbt_pkg::MAX_BYTES) begin
            wbuf[fill[5:0]] = it.data;
            fill++;
            if (int'(fill) > written) written = fill;
          end else begin
            counted = 1'b0;
          end
        end else begin
          is_rd = (it.op == i2cbt_pkg::OP_READ);
          if (!is_rd) fill = '0;
          n = (it.cnt > i2cbt_pkg::MAX_BYTES) ? i2cbt_pkg::MAX_BYTES : it.cnt;
          if (n == 0) begin
            res.done = 1'b1;
          end else begin
            left = 7'(n);
            start_addr = it.reg_addr;
            retries = 4'(i2cbt_pkg::SELECT_RETRIES);
            sendp = '0;
            stg = i2cbt_pkg::STG_DEV;
            ack = 1'b0;
            shift = '0;
            enter(i2cbt_pkg::PH_START);
          end
        end
      end
      if (ph != i2cbt_pkg::PH_IDLE) advance_bus(it.sda);
      res.scl = scl_l;
      res.sda = sda_l;
      pending_slots.push_back(res);
      return counted;
    endfunction

    task cmp(string name, logic [7:0] g, logic [7:0] w);
      if (g !== w) report($sformatf("item %0d %s got %0h want %0h", checked, name, g, w));
    endtask

    task check_slot(slot_out_t got);
      slot_out_t want;
      checked++;
      if (pending_slots.size() == 0) begin
        report($sformatf("item %0d arrived with nothing pending", checked));
        return;
      end
      want = pending_slots.pop_front();
      cmp("scl_low", got.scl, want.scl);
      cmp("sda_low", got.sda, want.sda);
      cmp("read_valid", got.rd_valid, want.rd_valid);
      cmp("read_byte", got.rd_byte, want.rd_byte);
      cmp("done_res", got.done, want.done);
      cmp("success", got.ok, want.ok);
      cmp("busy_res", got.busy, want.busy);
    endtask
  endclass
endpackage

module tb;

  localparam int STUCK_LIMIT = 3000;

  typedef struct {
    i2cbt_tb_pkg::slot_in_t it;
    int                     dev_nacks;
    int                     nack_at;
  } cmd_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] opcode = i2cbt_pkg::OP_TICK;
  logic       sda_in = 1'b1;
  logic [7:0] reg_address = '0;
  logic [6:0] byte_count = '0;
  logic [7:0] load_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl_low;
  logic       sda_low;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       done_res;
  logic       success;
  logic       busy_res;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  i2cbt_tb_pkg::slot_scoreboard sb = new();
  cmd_t                         cmd_q [$];
  int                           dev_nacks_left = 0;
  int                           nack_at = -1;
  int                           ack_no = 0;
  bit                           full_done = 1'b0;
  bit                           calm = 1'b0;
  int                           hold_left = 0;
  bit                           held = 1'b0;
  i2cbt_tb_pkg::slot_out_t      got_slot;

  i2c_block_transfer_master_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .sda_in     (sda_in),
    .reg_address(reg_address),
    .byte_count (byte_count),
    .load_byte  (load_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .scl_low    (scl_low),
    .sda_low    (sda_low),
    .read_valid (read_valid),
    .read_byte  (read_byte),
    .done_res   (done_res),
    .success    (success),
    .busy_res   (busy_res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic i2cbt_tb_pkg::slot_in_t noise_item();
    i2cbt_tb_pkg::slot_in_t it;
    it.op = 2'($urandom_range(0, 3));
    it.sda = 1'($urandom_range(0, 1));
    it.reg_addr = 8'($urandom_range(0, 255));
    it.cnt = 7'($urandom_range(0, 127));
    it.data = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic void push_cmd(logic [1:0] op, int ra, int cnt, int data, int dn, int na);
    cmd_t c;
    c.it = noise_item();
    c.it.op = op;
    c.it.reg_addr = 8'(ra);
    c.it.cnt = 7'(cnt);
    c.it.data = 8'(data);
    c.dev_nacks = dn;
    c.nack_at = na;
    cmd_q.push_back(c);
  endfunction

  function automatic int pick_dev_nacks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 0;
    if (r < 95) return $urandom_range(1, i2cbt_pkg::SELECT_RETRIES - 1);
    return i2cbt_pkg::SELECT_RETRIES;
  endfunction

  function automatic int pick_nack_at(int cnt);
    if ($urandom_range(0, 99) < 80) return -1;
    return $urandom_range(0, cnt + 1);
  endfunction

  // Loads then a write; never sends a buffer entry that was not loaded.
  function automatic void plan_write();
    int nload, nfill, w, cnt, r, i;
    r = $urandom_range(0, 99);
    if (!full_done || r < 3) begin
      nload = i2cbt_pkg::MAX_BYTES + $urandom_range(1, 3);
      full_done = 1'b1;
    end else if (r < 8) begin
      nload = $urandom_range(5, i2cbt_pkg::MAX_BYTES - 1);
    end else begin
      nload = $urandom_range(0, 4);
    end
    for (i = 0; i < nload; i++)
      push_cmd(i2cbt_pkg::OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 127),
               $urandom_range(0, 255), 0, -1);
    nfill = sb.fill + nload;
    if (nfill > i2cbt_pkg::MAX_BYTES) nfill = i2cbt_pkg::MAX_BYTES;
    w = (sb.written > nfill) ? sb.written : nfill;
    r = $urandom_range(0, 99);
    if (w == 0 || r < 5) cnt = 0;
    else if (w == i2cbt_pkg::MAX_BYTES && r < 15)
      cnt = $urandom_range(i2cbt_pkg::MAX_BYTES + 1, 127);
    else if (r < 70 && nfill > 0) cnt = nfill;
    else cnt = $urandom_range(1, w);
    push_cmd(i2cbt_pkg::OP_WRITE, $urandom_range(0, 255), cnt, $urandom_range(0, 255),
             pick_dev_nacks(), pick_nack_at(cnt));
  endfunction

  function automatic void plan_read();
    int cnt, r;
    r = $urandom_range(0, 99);
    if (r < 4) cnt = 0;
    else if (r < 9) cnt = $urandom_range(i2cbt_pkg::MAX_BYTES + 1, 127);
    else if (r < 15) cnt = $urandom_range(5, i2cbt_pkg::MAX_BYTES);
    else cnt = $urandom_range(1, 4);
    push_cmd(i2cbt_pkg::OP_READ, $urandom_range(0, 255), cnt, $urandom_range(0, 255),
             pick_dev_nacks(), pick_nack_at(cnt));
  endfunction

  // Next item from the model state after the last accepted item.
  function automatic i2cbt_tb_pkg::slot_in_t next_item();
    i2cbt_tb_pkg::slot_in_t it;
    cmd_t c;
    int r;
    it = noise_item();
    if (sb.ph != i2cbt_pkg::PH_IDLE) begin
      if ($urandom_range(0, 99) < 4) return it;
      it.op = i2cbt_pkg::OP_TICK;
      if (sb.ph == i2cbt_pkg::PH_SACK && sb.slot == 2'd1) begin
        if (sb.stg == i2cbt_pkg::STG_DEV) begin
          it.sda = (dev_nacks_left > 0);
          if (dev_nacks_left > 0) dev_nacks_left--;
        end else begin
          it.sda = (ack_no == nack_at);
          ack_no++;
        end
      end
      return it;
    end
    if (cmd_q.size() == 0) begin
      r = $urandom_range(0, 99);
      if (r < 10)
        push_cmd(i2cbt_pkg::OP_TICK, $urandom_range(0, 255), $urandom_range(0, 127),
                 $urandom_range(0, 255), 0, -1);
      else if (r < 55) plan_write();
      else plan_read();
    end
    c = cmd_q.pop_front();
    if (c.it.op == i2cbt_pkg::OP_READ || c.it.op == i2cbt_pkg::OP_WRITE) begin
      dev_nacks_left = c.dev_nacks;
      nack_at = c.nack_at;
      ack_no = 0;
    end
    return c.it;
  endfunction

  task automatic run_items(input int n);
    int taken;
    bit pending;
    i2cbt_tb_pkg::slot_in_t cur;
    taken = 0;
    pending = 1'b0;
    cur = '0;
    forever begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        if (sb.take_item(cur)) taken++;
        pending = 1'b0;
      end
      if (!pending) begin
        if (taken >= n && sb.ph == i2cbt_pkg::PH_IDLE && cmd_q.size() == 0) begin
          in_valid <= 1'b0;
          break;
        end
        if (!calm && $urandom_range(0, 99) < 27) begin
          in_valid <= 1'b0;
        end else begin
          cur = next_item();
          opcode <= cur.op;
          sda_in <= cur.sda;
          reg_address <= cur.reg_addr;
          byte_count <= cur.cnt;
          load_byte <= cur.data;
          in_valid <= 1'b1;
          pending = 1'b1;
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (sb.pending_slots.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_dev_addr(input logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.dev_addr = v;
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls plus one long hold-off that backs up the input.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_slot = {scl_low, sda_low, read_valid, read_byte, done_res, success, busy_res};
        sb.check_slot(got_slot);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held && sb.checked >= 700) begin
        held = 1'b1;
        hold_left = 200;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 27);
      end
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("[i2c_block_transfer_master_unit] ERROR");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // idle tick, zero counts, loads, acked write, absent device, saturated
    // read, select retry, data / register / read address NACKs
    push_cmd(i2cbt_pkg::OP_TICK,  8'h00, 0,   8'h00, 0, -1);
    push_cmd(i2cbt_pkg::OP_READ,  8'h10, 0,   8'h00, 0, -1);
    push_cmd(i2cbt_pkg::OP_WRITE, 8'h20, 0,   8'h00, 0, -1);
    push_cmd(i2cbt_pkg::OP_LOAD,  8'h00, 0,   8'hFF, 0, -1);
    push_cmd(i2cbt_pkg::OP_LOAD,  8'h00, 0,   8'h00, 0, -1);
    push_cmd(i2cbt_pkg::OP_LOAD,  8'h00, 0,   8'hA5, 0, -1);
    push_cmd(i2cbt_pkg::OP_WRITE, 8'hFF, 3,   8'h00, 0, -1);
    push_cmd(i2cbt_pkg::OP_READ,  8'h00, 1,   8'h00, i2cbt_pkg::SELECT_RETRIES, -1);
    push_cmd(i2cbt_pkg::OP_READ,  8'h5A, 127, 8'h00, 0, -1);
    push_cmd(i2cbt_pkg::OP_READ,  8'h33, 2,   8'h00, 2, -1);
    push_cmd(i2cbt_pkg::OP_LOAD,  8'h00, 0,   8'h01, 0, -1);
    push_cmd(i2cbt_pkg::OP_LOAD,  8'h00, 0,   8'h80, 0, -1);
    push_cmd(i2cbt_pkg::OP_WRITE, 8'hC3, 2,   8'h00, 0, 1);
    push_cmd(i2cbt_pkg::OP_WRITE, 8'h3C, 2,   8'h00, 0, 0);
    push_cmd(i2cbt_pkg::OP_READ,  8'h77, 3,   8'h00, 0, 1);
    push_cmd(i2cbt_pkg::OP_READ,  8'h00, 2,   8'h00, 0, 0);
    push_cmd(i2cbt_pkg::OP_WRITE, 8'h01, 1,   8'h00, i2cbt_pkg::SELECT_RETRIES, -1);
    run_items(0);
    wait_drained();

    write_dev_addr(8'h00);
    run_items(500);
    wait_drained();

    write_dev_addr(8'hFE);
    calm = 1'b1;
    run_items(500);
    calm = 1'b0;
    wait_drained();

    write_dev_addr(8'($urandom_range(0, 126) * 2 + 1));
    run_items(500);
    wait_drained();

    write_dev_addr(8'($urandom_range(0, 254)));
    run_items(500);
    wait_drained();

    if (sb.pending_slots.size() != 0)
      sb.report($sformatf("%0d items never produced a result", sb.pending_slots.size()));
    if (sb.errors == 0)
      $display("[i2c_block_transfer_master_unit] OK");
    else
      $display("[i2c_block_transfer_master_unit] ERROR");
    $finish;
  end
endmodule
